// ===== rtl/core/lfk_pkg.sv =====
// ----------------------------------------------------------------------------
// lfk_pkg
// Shared constants for the leg forward kinematics datapath.
// ----------------------------------------------------------------------------
package lfk_pkg;

  localparam int unsigned NUM_REGS     = 5;
  localparam int unsigned CORDIC_STEPS = 28;
  // angles reg, phase reg, CORDIC load plus steps, trig, shin, products
  localparam int unsigned NUM_STAGES   = 2 + CORDIC_STEPS + 1 + 3;

  localparam logic [31:0]        PHASE_PER_Q13 = 32'd83443;
  localparam logic signed [33:0] CORDIC_X0     = 34'sd652032874;

  localparam logic [2:0] REG_HIP_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_HIP_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_HIP_LENGTH_Y   = 3'd2;
  localparam logic [2:0] REG_THIGH_LENGTH_Z = 3'd3;
  localparam logic [2:0] REG_SHIN_LENGTH_Z  = 3'd4;

  localparam logic signed [14:0] RST_HIP_OFFSET_X   = 15'sd3113;
  localparam logic signed [14:0] RST_HIP_OFFSET_Y   = 15'sd803;
  localparam logic signed [14:0] RST_HIP_LENGTH_Y   = 15'sd1016;
  localparam logic signed [14:0] RST_THIGH_LENGTH_Z = -15'sd3424;
  localparam logic signed [14:0] RST_SHIN_LENGTH_Z  = -15'sd3277;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
    32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608,
    32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41, 32'sd20,
    32'sd10, 32'sd5
  };

endpackage

// ===== rtl/core/leg_forward_kinematics.sv =====
// Throughput: one item per cycle; the whole pipeline advances together
// and holds while a result waits at the output.
// The 28-step CORDIC pipeline, three lanes wide, sets the depth.
// Reset clears valid bits and loads link length registers with defaults.
// ----------------------------------------------------------------------------
// leg_forward_kinematics
// Foot position of a three-joint leg from its joint angles.
// ----------------------------------------------------------------------------
module leg_forward_kinematics (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // hip_angle, thigh_angle, knee_angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // foot_x, foot_y, foot_z
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int unsigned NS = lfk_pkg::NUM_STAGES;
  localparam int unsigned CS = lfk_pkg::CORDIC_STEPS;

  logic en;
  logic [NS-1:0] vld;

  logic signed [14:0] hip_offset_x, hip_offset_y, hip_length_y;
  logic signed [14:0] thigh_length_z, shin_length_z;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hip_offset_x   <= lfk_pkg::RST_HIP_OFFSET_X;
      hip_offset_y   <= lfk_pkg::RST_HIP_OFFSET_Y;
      hip_length_y   <= lfk_pkg::RST_HIP_LENGTH_Y;
      thigh_length_z <= lfk_pkg::RST_THIGH_LENGTH_Z;
      shin_length_z  <= lfk_pkg::RST_SHIN_LENGTH_Z;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfk_pkg::REG_HIP_OFFSET_X:   hip_offset_x   <= cfg_data;
        lfk_pkg::REG_HIP_OFFSET_Y:   hip_offset_y   <= cfg_data;
        lfk_pkg::REG_HIP_LENGTH_Y:   hip_length_y   <= cfg_data;
        lfk_pkg::REG_THIGH_LENGTH_Z: thigh_length_z <= cfg_data;
        lfk_pkg::REG_SHIN_LENGTH_Z:  shin_length_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NS-2:0], s_tvalid};
      m_tvalid <= vld[NS-1];
    end
  end

  // stage: angles, sum wrapped later by the phase
  logic signed [15:0] ang_h, ang_t, ang_k;
  always_ff @(posedge clk) begin
    if (en) begin
      ang_h <= s_tdata[15:0];
      ang_t <= s_tdata[31:16];
      ang_k <= s_tdata[47:32];
    end
  end

  logic signed [16:0] ang_tk;
  logic [31:0] ang32 [3];
  assign ang_tk   = 17'(ang_t) + 17'(ang_k);
  assign ang32[0] = {{16{ang_h[15]}}, ang_h};
  assign ang32[1] = {{16{ang_t[15]}}, ang_t};
  assign ang32[2] = {{15{ang_tk[16]}}, ang_tk};

  // stage: phase, one full turn is 2^32
  logic [31:0] phase [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) phase[l] <= ang32[l] * lfk_pkg::PHASE_PER_Q13;
    end
  end

  logic signed [33:0] cx [CS+1][3];
  logic signed [33:0] cy [CS+1][3];
  logic signed [31:0] cz [CS+1][3];
  logic [1:0]         cq [CS+1][3];

  logic [1:0]  q0 [3];
  logic [31:0] ph_adj [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ph_adj[l] = phase[l] + 32'h2000_0000;
      q0[l]     = ph_adj[l][31:30];
    end
  end

  // load the CORDIC with the residual after the nearest quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        cx[0][l] <= lfk_pkg::CORDIC_X0;
        cy[0][l] <= '0;
        cz[0][l] <= phase[l] - {q0[l], 30'd0};
        cq[0][l] <= q0[l];
      end
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (!cz[i][l][31]) begin
            cx[i+1][l] <= cx[i][l] - (cy[i][l] >>> i);
            cy[i+1][l] <= cy[i][l] + (cx[i][l] >>> i);
            cz[i+1][l] <= cz[i][l] - lfk_pkg::ATAN_TURN[i];
          end else begin
            cx[i+1][l] <= cx[i][l] + (cy[i][l] >>> i);
            cy[i+1][l] <= cy[i][l] - (cx[i][l] >>> i);
            cz[i+1][l] <= cz[i][l] + lfk_pkg::ATAN_TURN[i];
          end
          cq[i+1][l] <= cq[i][l];
        end
      end
    end
  end

  // quadrant swap and round Q30 to Q16
  logic signed [33:0] xr [3];
  logic signed [33:0] yr [3];
  logic signed [33:0] xq, yq;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      case (cq[CS][l])
        2'd0: begin xq = cx[CS][l];  yq = cy[CS][l];  end
        2'd1: begin xq = -cy[CS][l]; yq = cx[CS][l];  end
        2'd2: begin xq = -cx[CS][l]; yq = -cy[CS][l]; end
        default: begin xq = cy[CS][l]; yq = -cx[CS][l]; end
      endcase
      xr[l] = (xq + 34'sd8192) >>> 14;
      yr[l] = (yq + 34'sd8192) >>> 14;
    end
  end

  logic signed [17:0] cs_c [3];
  logic signed [17:0] cs_s [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        cs_c[l] <= xr[l][17:0];
        cs_s[l] <= yr[l][17:0];
      end
    end
  end

  // shin vector in Q16
  logic signed [33:0] shin_z, shin_x;
  logic signed [17:0] c1, s1;
  always_ff @(posedge clk) begin
    if (en) begin
      shin_z <= 34'(thigh_length_z * cs_c[1]) + 34'(shin_length_z * cs_c[2]);
      shin_x <= 34'(thigh_length_z * cs_s[1]) + 34'(shin_length_z * cs_s[2]);
      c1     <= cs_c[0];
      s1     <= cs_s[0];
    end
  end

  logic signed [32:0] p_hc, p_hs;
  logic signed [51:0] p_zs, p_zc;
  logic signed [18:0] fx;
  logic signed [33:0] shin_x_r;
  assign shin_x_r = (shin_x + 34'sd32768) >>> 16;
  always_ff @(posedge clk) begin
    if (en) begin
      p_hc <= 33'(hip_length_y * c1);
      p_hs <= 33'(hip_length_y * s1);
      p_zs <= 52'(shin_z * s1);
      p_zc <= 52'(shin_z * c1);
      fx   <= 19'(hip_offset_x) + shin_x_r[18:0];
    end
  end

  logic signed [55:0] sum_y, sum_z, sh_y, sh_z;
  logic signed [15:0] fx_sat, fy_sat, fz_sat;
  always_comb begin
    sum_y = (56'(p_hc) <<< 16) - 56'(p_zs) + (56'(hip_offset_y) <<< 32)
            + 56'sh8000_0000;
    sum_z = (56'(p_hc) * 0) + (56'(p_hs) <<< 16) + 56'(p_zc) + 56'sh8000_0000;
    sh_y  = sum_y >>> 32;
    sh_z  = sum_z >>> 32;
    if (fx > 19'sd32767) fx_sat = 16'sh7fff;
    else if (fx < -19'sd32768) fx_sat = 16'sh8000;
    else fx_sat = fx[15:0];
    if (sh_y > 56'sd32767) fy_sat = 16'sh7fff;
    else if (sh_y < -56'sd32768) fy_sat = 16'sh8000;
    else fy_sat = sh_y[15:0];
    if (sh_z > 56'sd32767) fz_sat = 16'sh7fff;
    else if (sh_z < -56'sd32768) fz_sat = 16'sh8000;
    else fz_sat = sh_z[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) m_tdata <= {fz_sat, fy_sat, fx_sat};
  end

`ifndef ASSERT_OFF
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid && vld == '0)
    else $error("pipeline not empty after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld))
    else $error("valid chain moved during stall");
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    (s_tready && vld[NS-1]) |=> m_tvalid)
    else $error("item lost at output stage");
`endif

endmodule

// ===== verif/leg_forward_kinematics_tb.sv =====
// ----------------------------------------------------------------------------
// leg_forward_kinematics_tb
// Drives joint-angle items through the leg forward kinematics block under
// random sender gaps and receiver stalls, and checks every foot position
// against an in-bench fixed-point CORDIC predictor across several link-length
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module leg_forward_kinematics_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class foot_scoreboard;
    logic signed [14:0] link [lfk_pkg::NUM_REGS];
    logic [47:0]        pending_feet [$];
    int                 errors;

    function new();
      link[lfk_pkg::REG_HIP_OFFSET_X]   = lfk_pkg::RST_HIP_OFFSET_X;
      link[lfk_pkg::REG_HIP_OFFSET_Y]   = lfk_pkg::RST_HIP_OFFSET_Y;
      link[lfk_pkg::REG_HIP_LENGTH_Y]   = lfk_pkg::RST_HIP_LENGTH_Y;
      link[lfk_pkg::REG_THIGH_LENGTH_Z] = lfk_pkg::RST_THIGH_LENGTH_Z;
      link[lfk_pkg::REG_SHIN_LENGTH_Z]  = lfk_pkg::RST_SHIN_LENGTH_Z;
      errors = 0;
    endfunction

    function void set_link(logic [2:0] idx, logic [14:0] val);
      if (idx < lfk_pkg::NUM_REGS) link[idx] = val;
    endfunction

    // angle in Q13 radians -> cosine and sine in Q16
    function void trig(longint angle, output longint c, output longint s);
      logic [31:0] phase, resid;
      logic [1:0]  quad;
      longint      z, x, y, xn, yn;
      phase = 32'(angle) * lfk_pkg::PHASE_PER_Q13;
      quad  = 2'((phase + 32'h2000_0000) >> 30);
      resid = phase - {quad, 30'd0};
      z = longint'(signed'(resid));
      x = longint'(lfk_pkg::CORDIC_X0);
      y = 0;
      for (int i = 0; i < lfk_pkg::CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          xn = x - (y >>> i); yn = y + (x >>> i); z -= longint'(lfk_pkg::ATAN_TURN[i]);
        end else begin
          xn = x + (y >>> i); yn = y - (x >>> i); z += longint'(lfk_pkg::ATAN_TURN[i]);
        end
        x = xn; y = yn;
      end
      case (quad)
        2'd0: begin xn = x;  yn = y;  end
        2'd1: begin xn = -y; yn = x;  end
        2'd2: begin xn = -x; yn = -y; end
        default: begin xn = y; yn = -x; end
      endcase
      c = (xn + 8192) >>> 14;
      s = (yn + 8192) >>> 14;
    endfunction

    function logic [15:0] clamp16(longint v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return 16'(v);
    endfunction

    function void note_angles(logic [47:0] angles);
      longint h, t, k, c1, s1, c2, s2, c23, s23, sz, sx, fx, fy, fz;
      longint ox, oy, ly, lt, ls;
      h = longint'(signed'(angles[15:0]));
      t = longint'(signed'(angles[31:16]));
      k = longint'(signed'(angles[47:32]));
      ox = link[lfk_pkg::REG_HIP_OFFSET_X];   oy = link[lfk_pkg::REG_HIP_OFFSET_Y];
      ly = link[lfk_pkg::REG_HIP_LENGTH_Y];   lt = link[lfk_pkg::REG_THIGH_LENGTH_Z];
      ls = link[lfk_pkg::REG_SHIN_LENGTH_Z];
      trig(h, c1, s1);
      trig(t, c2, s2);
      trig(t + k, c23, s23);
      sz = lt * c2 + ls * c23;
      sx = lt * s2 + ls * s23;
      fx = ox + ((sx + 32768) >>> 16);
      fy = (ly * c1 * 65536 - sz * s1 + oy * 64'sd4294967296 + 64'sd2147483648) >>> 32;
      fz = (ly * s1 * 65536 + sz * c1 + 64'sd2147483648) >>> 32;
      pending_feet.push_back({clamp16(fz), clamp16(fy), clamp16(fx)});
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      errors++;
    endtask

    task check_foot(logic [47:0] got);
      logic [47:0] want;
      if (pending_feet.size() == 0) begin
        $display("unexpected foot item %h", got);
        errors++;
        return;
      end
      want = pending_feet.pop_front();
      if (got[15:0] !== want[15:0]) report("foot_x", got[15:0], want[15:0]);
      if (got[31:16] !== want[31:16]) report("foot_y", got[31:16], want[31:16]);
      if (got[47:32] !== want[47:32]) report("foot_z", got[47:32], want[47:32]);
    endtask
  endclass

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [47:0] s_tdata, m_tdata;   // s: hip, thigh, knee; m: foot_x, foot_y, foot_z
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [14:0] cfg_data;

  foot_scoreboard sb;
  int  idle_cycles;
  int  stall_mode;

  leg_forward_kinematics dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall pattern: free run, random, or mostly stalled
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 15) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_foot(m_tdata);
    if (!rst && s_tvalid && s_tready) sb.note_angles(s_tdata);
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL leg_forward_kinematics");
      $finish;
    end
  end

  task send_angles(logic [47:0] angles);
    s_tvalid <= 1'b1;
    s_tdata  <= angles;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task stop_sending();
    s_tvalid <= 1'b0;
  endtask

  task drain();
    stop_sending();
    while (sb.pending_feet.size() != 0) @(negedge clk);
    repeat (lfk_pkg::NUM_STAGES + 4) @(negedge clk);
  endtask

  // cfg_valid is released after every write
  task write_link(logic [2:0] idx, logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_link(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000 ^ 16'($urandom_range(0, 3));
      1: return 16'h7fff - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(0, 25736)) - 16'd12868;   // within +-pi/2
      default: return 16'($urandom);
    endcase
  endfunction

  task random_burst(int count);
    int left;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 24); b > 0 && left > 0; b--) begin
        send_angles({pick_angle(), pick_angle(), pick_angle()});
        left--;
      end
      if ($urandom_range(0, 2) == 0) begin
        stop_sending();
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  endtask

  task set_all(logic [14:0] ox, logic [14:0] oy, logic [14:0] ly,
               logic [14:0] lt, logic [14:0] ls);
    write_link(lfk_pkg::REG_HIP_OFFSET_X, ox);
    write_link(lfk_pkg::REG_HIP_OFFSET_Y, oy);
    write_link(lfk_pkg::REG_HIP_LENGTH_Y, ly);
    write_link(lfk_pkg::REG_THIGH_LENGTH_Z, lt);
    write_link(lfk_pkg::REG_SHIN_LENGTH_Z, ls);
  endtask

  initial begin
    logic [15:0] dir_angles [8];
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    stall_mode = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: angle extremes, quadrant edges and the knee wrap
    dir_angles = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'd12868,
                   -16'sd12868, 16'd25736, 16'd6434};
    for (int i = 0; i < 8; i++)
      send_angles({dir_angles[(i + 3) % 8], dir_angles[(i + 5) % 8], dir_angles[i]});
    send_angles({16'h7fff, 16'h7fff, 16'h0000});
    send_angles({16'h8000, 16'h8000, 16'h1234});
    drain();

    // write indices past the last register, which the block ignores
    write_link(3'd5, 15'h1555);
    write_link(3'd7, 15'h2aaa);
    // extremes: positive and negative full scale, forcing saturation
    set_all(15'h3fff, 15'h3fff, 15'h3fff, 15'h3fff, 15'h3fff);
    for (int i = 0; i < 6; i++)
      send_angles({dir_angles[i], dir_angles[i + 1], dir_angles[i + 2]});
    drain();
    set_all(15'h4000, 15'h4000, 15'h4000, 15'h4000, 15'h4000);
    for (int i = 0; i < 6; i++)
      send_angles({dir_angles[i + 2], dir_angles[i], dir_angles[i + 1]});
    drain();

    // random phases, each under its own link setting, cycling through the stall patterns
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      if (ph == 0) set_all(lfk_pkg::RST_HIP_OFFSET_X, lfk_pkg::RST_HIP_OFFSET_Y,
                           lfk_pkg::RST_HIP_LENGTH_Y, lfk_pkg::RST_THIGH_LENGTH_Z,
                           lfk_pkg::RST_SHIN_LENGTH_Z);
      else if (ph == 5) set_all(15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000);
      else set_all(15'($urandom), 15'($urandom), 15'($urandom),
                   15'($urandom), 15'($urandom));
      random_burst(120);
      drain();   // hold off until every foot item is back
      random_burst(120);
      drain();
    end

    if (sb.errors == 0 && sb.pending_feet.size() == 0)
      $display("PASS leg_forward_kinematics");
    else
      $display("FAIL leg_forward_kinematics");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/lfk_pkg.sv
rtl/core/leg_forward_kinematics.sv
verif/leg_forward_kinematics_tb.sv
